[sv/rcdt_pkg.sv]
`default_nettype none

package rcdt_pkg;

    localparam int ENTRIES      = 10;
    localparam int CALL_CHARS   = 6;
    localparam int IN_CHARS     = 6;
    localparam int CHAR_W       = 7;
    localparam int RAW_W        = 8;
    localparam int SSID_W       = 3;
    localparam int STORED_CHARS = (CALL_CHARS < IN_CHARS) ? CALL_CHARS : IN_CHARS;
    localparam int ENTRY_W      = STORED_CHARS * CHAR_W + SSID_W;
    localparam int IDX_W        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W        = $clog2(ENTRIES + 1);

    localparam int IN_BITS      = IN_CHARS * RAW_W + RAW_W;
    localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS     = IN_CHARS * CHAR_W + SSID_W;
    localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_DUMP = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_DUMP   = 3'b100
    } t_state;

endpackage

`default_nettype wire

[sv/recent_callsign_dedup_table_unit.sv]
`default_nettype none

// channel   dir  tdata                                      tuser        tlast
// s (in)    in   raw_char_0..raw_char_5, ssid_byte (56 b)   command      -
// m (out)   out  out_char_0..out_char_5, ssid_number (48 b) entry_valid  last_entry
//
// add: one table entry compared per cycle through the single read port of the
// entry memory, write-back on a miss in the last compare cycle
// dump: one entry per cycle while the output is taken, ENTRIES words, last flagged
// input is taken only in idle; a stalled output holds the dump at the read port
// reset clears valid bits and the write slot; entry memory needs no clearing

module recent_callsign_dedup_table_unit
    import rcdt_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    // raw_char_0 .. raw_char_5, ssid_byte
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    // command
    input  wire logic                   i_s_tuser,
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    // out_char_0 .. out_char_5, ssid_number, zero fill
    output logic      [OUT_TDATA_W-1:0] o_m_tdata,
    // entry_valid
    output logic                        o_m_tuser,
    output logic                        o_m_tlast
);

    t_state                   r_state, n_state;
    logic [ENTRIES-1:0]       r_valid, n_valid;
    logic [IDX_W-1:0]         r_wslot, n_wslot;
    logic [CNT_W-1:0]         r_idx, n_idx;
    logic [IDX_W-1:0]         r_cmp_idx, n_cmp_idx;
    logic                     r_cmp_en, n_cmp_en;
    logic                     r_hit, n_hit;
    logic [ENTRY_W-1:0]       r_entry, n_entry;
    logic                     r_pend, n_pend;
    logic [IDX_W-1:0]         r_pend_idx, n_pend_idx;
    logic                     r_out_vld, n_out_vld;
    logic [OUT_TDATA_W-1:0]   r_out_data, n_out_data;
    logic                     r_out_valid_flag, n_out_valid_flag;
    logic                     r_out_last, n_out_last;

    logic                     s_acc;
    logic                     can_load;
    logic                     cur_hit;
    logic                     ram_we;
    logic [IDX_W-1:0]         ram_raddr;
    logic [ENTRY_W-1:0]       ram_rdata;
    logic [ENTRY_W-1:0]       dec_entry;
    logic [OUT_TDATA_W-1:0]   fmt_data;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign can_load   = !r_out_vld || i_m_tready;

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_valid_flag;
    assign o_m_tlast  = r_out_last;

    // decode: characters shifted down one, ssid from bits 3:1
    always_comb begin
        dec_entry = '0;
        for (int i = 0; i < STORED_CHARS; i++) begin
            dec_entry[i*CHAR_W +: CHAR_W] = i_s_tdata[i*RAW_W + 1 +: CHAR_W];
        end
        dec_entry[STORED_CHARS*CHAR_W +: SSID_W] = i_s_tdata[IN_CHARS*RAW_W + 1 +: SSID_W];
    end

    // output word from a stored entry, zero for an unwritten slot
    always_comb begin
        fmt_data = '0;
        if (r_valid[r_pend_idx]) begin
            for (int i = 0; i < STORED_CHARS; i++) begin
                fmt_data[i*CHAR_W +: CHAR_W] = ram_rdata[i*CHAR_W +: CHAR_W];
            end
            fmt_data[IN_CHARS*CHAR_W +: SSID_W] = ram_rdata[STORED_CHARS*CHAR_W +: SSID_W];
        end
    end

    assign cur_hit = r_cmp_en && r_valid[r_cmp_idx] && (ram_rdata == r_entry);

    always_comb begin
        n_state          = r_state;
        n_valid          = r_valid;
        n_wslot          = r_wslot;
        n_idx            = r_idx;
        n_cmp_idx        = r_cmp_idx;
        n_cmp_en         = 1'b0;
        n_hit            = r_hit;
        n_entry          = r_entry;
        n_pend           = r_pend;
        n_pend_idx       = r_pend_idx;
        n_out_vld        = r_out_vld;
        n_out_data       = r_out_data;
        n_out_valid_flag = r_out_valid_flag;
        n_out_last       = r_out_last;
        ram_we           = 1'b0;
        ram_raddr        = r_idx[IDX_W-1:0];

        if (r_out_vld && i_m_tready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_idx = '0;
                    if (i_s_tuser == CMD_ADD) begin
                        n_entry = dec_entry;
                        n_hit   = 1'b0;
                        n_state = S_SEARCH;
                    end else begin
                        n_pend  = 1'b0;
                        n_state = S_DUMP;
                    end
                end
            end
            S_SEARCH: begin
                // compare runs in the cycle after its read address
                if (r_idx < CNT_W'(ENTRIES)) begin
                    n_idx     = r_idx + 1'b1;
                    n_cmp_en  = 1'b1;
                    n_cmp_idx = r_idx[IDX_W-1:0];
                end
                n_hit = r_hit || cur_hit;
                if (r_cmp_en && r_cmp_idx == IDX_W'(ENTRIES - 1)) begin
                    if (!(r_hit || cur_hit)) begin
                        ram_we           = 1'b1;
                        n_valid[r_wslot] = 1'b1;
                        n_wslot          = (r_wslot == IDX_W'(ENTRIES - 1)) ? '0
                                                                            : r_wslot + 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            S_DUMP: begin
                // on a stall the pending address is read again so the data holds
                ram_raddr = r_pend_idx;
                if (r_pend && can_load) begin
                    n_out_vld        = 1'b1;
                    n_out_data       = fmt_data;
                    n_out_valid_flag = r_valid[r_pend_idx];
                    n_out_last       = (r_pend_idx == IDX_W'(ENTRIES - 1));
                    n_pend           = 1'b0;
                    if (r_pend_idx == IDX_W'(ENTRIES - 1)) begin
                        n_state = S_IDLE;
                    end
                end
                if ((r_idx < CNT_W'(ENTRIES)) && (!r_pend || can_load)) begin
                    ram_raddr  = r_idx[IDX_W-1:0];
                    n_pend     = 1'b1;
                    n_pend_idx = r_idx[IDX_W-1:0];
                    n_idx      = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_wslot   <= '0;
            r_idx     <= '0;
            r_cmp_en  <= 1'b0;
            r_hit     <= 1'b0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_wslot   <= n_wslot;
            r_idx     <= n_idx;
            r_cmp_en  <= n_cmp_en;
            r_hit     <= n_hit;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx        <= n_cmp_idx;
        r_entry          <= n_entry;
        r_pend_idx       <= n_pend_idx;
        r_out_data       <= n_out_data;
        r_out_valid_flag <= n_out_valid_flag;
        r_out_last       <= n_out_last;
    end

    rcdt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wslot),
        .i_wdata (r_entry),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    a_write_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_SEARCH))
        else $error("entry write outside search");

    a_wslot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wslot <= IDX_W'(ENTRIES - 1))
        else $error("write slot out of range");

    a_no_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend)
        else $error("dump read left pending in idle");

    a_write_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> r_valid[$past(r_wslot)])
        else $error("written slot not marked valid");

    a_last_ends_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP && r_pend && can_load && r_pend_idx == IDX_W'(ENTRIES - 1))
        |=> (r_state == S_IDLE) && o_m_tvalid && o_m_tlast)
        else $error("last dump word did not end the dump");

endmodule

`default_nettype wire

[sv/rcdt_ram.sv]
`default_nettype none

module rcdt_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
